>>> src/cda_pkg.sv
// Shared types, constants and the month-length helper for the calendar date adder.
// Used by the channel interfaces, the controller, the datapath and the checker.
package cda_pkg;

	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned AMOUNT_W = 12;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned YEAR_W   = 15;

	localparam int unsigned AMOUNT_MAX_DEF = 4095;
	localparam int unsigned AMOUNT_FIELD_MAX = (1 << AMOUNT_W) - 1;

	localparam logic [YEAR_W-1:0]  YEAR_MAX      = '1;
	localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_FIRST     = 5'd1;
	localparam logic [DAY_W-1:0]   DAY_DEC_LAST  = 5'd31;
	localparam logic [DAY_W-1:0]   DAYS_FEB_LEAP = 5'd29;

	localparam int unsigned DAYS_PER_WEEK   = 7;
	localparam int unsigned YEARS_PER_DECADE = 10;
	localparam int unsigned MONTHS_PER_YEAR = 12;

	// Reciprocal constants: floor(x / 100) for x below 2**15, floor(x / 12) below 2**13.
	localparam int unsigned DIV100_MUL = 5243;
	localparam int unsigned DIV100_SH  = 19;
	localparam int unsigned DIV12_MUL  = 2731;
	localparam int unsigned DIV12_SH   = 15;

	localparam logic [DAY_W-1:0] MONTH_DAYS [MONTHS_PER_YEAR] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [OPCODE_W-1:0] {
		OP_DAYS    = 3'd0,
		OP_WEEKS   = 3'd1,
		OP_MONTHS  = 3'd2,
		OP_YEARS   = 3'd3,
		OP_DECADES = 3'd4
	} op_e;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VWAIT1,
		ST_VWAIT2,
		ST_CHECK,
		ST_WALK,
		ST_YWAIT1,
		ST_YWAIT2,
		ST_MDIV,
		ST_MAPPLY,
		ST_YADD,
		ST_YSAT,
		ST_CWAIT1,
		ST_CWAIT2,
		ST_CLAMP,
		ST_DONE
	} state_e;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_BAD,
		CMD_WALK,
		CMD_MDIV,
		CMD_MAPPLY,
		CMD_YADD,
		CMD_YSAT,
		CMD_CLAMP,
		CMD_EMIT
	} dp_cmd_e;

	typedef struct packed {
		dp_cmd_e cmd;
	} dp_ctrl_t;

	typedef struct packed {
		logic                date_ok;
		logic [OPCODE_W-1:0] opcode;
		logic                walk_fits;
		logic                month_dec;
		logic                year_max;
		logic                out_free;
	} dp_stat_t;

	// Length of month m, or zero for a month number outside the year.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		if (m < MONTH_JAN || m > MONTH_DEC) begin
			len = '0;
		end else if (m == MONTH_FEB && leap) begin
			len = DAYS_FEB_LEAP;
		end else begin
			len = MONTH_DAYS[m - MONTH_JAN];
		end
		return len;
	endfunction

endpackage

>>> src/cda_req_if.sv
// Request channel of the calendar date adder: valid, ready and the start date.
// Depends on cda_pkg for the field widths.
interface cda_req_if;
	logic                         valid;
	logic                         ready;
	logic [cda_pkg::OPCODE_W-1:0] opcode;
	logic [cda_pkg::AMOUNT_W-1:0] amount;
	logic [cda_pkg::DAY_W-1:0]    start_day;
	logic [cda_pkg::MONTH_W-1:0]  start_month;
	logic [cda_pkg::YEAR_W-1:0]   start_year;

	modport source (output valid, opcode, amount, start_day, start_month, start_year,
		input ready);
	modport sink (input valid, opcode, amount, start_day, start_month, start_year,
		output ready);
endinterface

>>> src/cda_rsp_if.sv
// Response channel of the calendar date adder: valid, ready, the end date and flags.
// Depends on cda_pkg for the field widths.
interface cda_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [cda_pkg::DAY_W-1:0]   end_day;
	logic [cda_pkg::MONTH_W-1:0] end_month;
	logic [cda_pkg::YEAR_W-1:0]  end_year;
	logic                        year_overflow;
	logic                        bad_date;

	modport source (output valid, end_day, end_month, end_year, year_overflow, bad_date,
		input ready);
	modport sink (input valid, end_day, end_month, end_year, year_overflow, bad_date,
		output ready);
endinterface

>>> src/calendar_date_adder_unit.sv
// Top level of the calendar date adder: controller, datapath and channel ports.
// Depends on cda_pkg, cda_req_if, cda_rsp_if, cda_ctrl and cda_dpath.
//
// Channel  Modport  Carries
// req      sink     opcode, amount, start_day, start_month, start_year
// rsp      source   end_day, end_month, end_year, year_overflow, bad_date
//
// After the accepting edge a request waits in VWAIT1 and VWAIT2 for the date check. Day
// and week steps then walk month by month, waiting in YWAIT1 and YWAIT2 per year crossed;
// month steps run MDIV and MAPPLY, year and decade steps YADD, then both YSAT, CWAIT1,
// CWAIT2 and CLAMP. DONE loads the output register when free. The walk sets the worst case.
// Reset clears the controller and the output valid; no memory needs clearing.
// A finished result waits in the output register while the next request is taken.
module calendar_date_adder_unit #(
	parameter int unsigned AMOUNT_MAX = cda_pkg::AMOUNT_MAX_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cda_req_if.sink   req,
	cda_rsp_if.source rsp
);

	cda_pkg::dp_ctrl_t ctrl;
	cda_pkg::dp_stat_t stat;

	cda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	cda_dpath #(
		.AMOUNT_MAX (AMOUNT_MAX)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.opcode        (req.opcode),
		.amount        (req.amount),
		.start_day     (req.start_day),
		.start_month   (req.start_month),
		.start_year    (req.start_year),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.end_day       (rsp.end_day),
		.end_month     (rsp.end_month),
		.end_year      (rsp.end_year),
		.year_overflow (rsp.year_overflow),
		.bad_date      (rsp.bad_date)
	);

endmodule

>>> src/cda_ctrl.sv
// Sequencing state machine of the calendar date adder.
// Depends on cda_pkg; drives datapath commands from datapath status.
module cda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cda_pkg::dp_stat_t stat,
	output cda_pkg::dp_ctrl_t ctrl
);

	cda_pkg::state_e state_q;
	cda_pkg::state_e state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl.cmd = cda_pkg::CMD_NONE;
		in_ready = 1'b0;
		case (state_q)
			cda_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.cmd = cda_pkg::CMD_LOAD;
					state_d  = cda_pkg::ST_VWAIT1;
				end
			end
			cda_pkg::ST_VWAIT1: state_d = cda_pkg::ST_VWAIT2;
			cda_pkg::ST_VWAIT2: state_d = cda_pkg::ST_CHECK;
			cda_pkg::ST_CHECK: begin
				if (!stat.date_ok) begin
					ctrl.cmd = cda_pkg::CMD_BAD;
					state_d  = cda_pkg::ST_DONE;
				end else begin
					case (stat.opcode)
						cda_pkg::OP_DAYS, cda_pkg::OP_WEEKS: state_d = cda_pkg::ST_WALK;
						cda_pkg::OP_MONTHS: state_d = cda_pkg::ST_MDIV;
						cda_pkg::OP_YEARS, cda_pkg::OP_DECADES: state_d = cda_pkg::ST_YADD;
						default: state_d = cda_pkg::ST_DONE;
					endcase
				end
			end
			cda_pkg::ST_WALK: begin
				ctrl.cmd = cda_pkg::CMD_WALK;
				if (stat.walk_fits || (stat.month_dec && stat.year_max)) begin
					state_d = cda_pkg::ST_DONE;
				end else if (stat.month_dec) begin
					state_d = cda_pkg::ST_YWAIT1;
				end
			end
			cda_pkg::ST_YWAIT1: state_d = cda_pkg::ST_YWAIT2;
			cda_pkg::ST_YWAIT2: state_d = cda_pkg::ST_WALK;
			cda_pkg::ST_MDIV: begin
				ctrl.cmd = cda_pkg::CMD_MDIV;
				state_d  = cda_pkg::ST_MAPPLY;
			end
			cda_pkg::ST_MAPPLY: begin
				ctrl.cmd = cda_pkg::CMD_MAPPLY;
				state_d  = cda_pkg::ST_YSAT;
			end
			cda_pkg::ST_YADD: begin
				ctrl.cmd = cda_pkg::CMD_YADD;
				state_d  = cda_pkg::ST_YSAT;
			end
			cda_pkg::ST_YSAT: begin
				ctrl.cmd = cda_pkg::CMD_YSAT;
				state_d  = cda_pkg::ST_CWAIT1;
			end
			cda_pkg::ST_CWAIT1: state_d = cda_pkg::ST_CWAIT2;
			cda_pkg::ST_CWAIT2: state_d = cda_pkg::ST_CLAMP;
			cda_pkg::ST_CLAMP: begin
				ctrl.cmd = cda_pkg::CMD_CLAMP;
				state_d  = cda_pkg::ST_DONE;
			end
			cda_pkg::ST_DONE: begin
				if (stat.out_free) begin
					ctrl.cmd = cda_pkg::CMD_EMIT;
					state_d  = cda_pkg::ST_IDLE;
				end
			end
			default: state_d = cda_pkg::ST_IDLE;
		endcase
	end

endmodule

>>> src/cda_dpath.sv
// Datapath of the calendar date adder: date registers, leap-year pipeline,
// month divider, year adder and the output register. Depends on cda_pkg.
module cda_dpath #(
	parameter int unsigned AMOUNT_MAX = cda_pkg::AMOUNT_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cda_pkg::dp_ctrl_t             ctrl,
	output cda_pkg::dp_stat_t             stat,
	input  logic [cda_pkg::OPCODE_W-1:0]  opcode,
	input  logic [cda_pkg::AMOUNT_W-1:0]  amount,
	input  logic [cda_pkg::DAY_W-1:0]     start_day,
	input  logic [cda_pkg::MONTH_W-1:0]   start_month,
	input  logic [cda_pkg::YEAR_W-1:0]    start_year,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cda_pkg::DAY_W-1:0]     end_day,
	output logic [cda_pkg::MONTH_W-1:0]   end_month,
	output logic [cda_pkg::YEAR_W-1:0]    end_year,
	output logic                          year_overflow,
	output logic                          bad_date
);

	localparam int unsigned N_MAX = (AMOUNT_MAX < cda_pkg::AMOUNT_FIELD_MAX) ?
		AMOUNT_MAX : cda_pkg::AMOUNT_FIELD_MAX;
	localparam int unsigned REM_W = $clog2(N_MAX * cda_pkg::DAYS_PER_WEEK + 1);
	localparam int unsigned CMP_W = 16;
	localparam int unsigned YSUM_W = cda_pkg::YEAR_W + 2;
	localparam int unsigned Q100_W = 9;
	localparam int unsigned P100_W = cda_pkg::YEAR_W + 13;
	localparam int unsigned T_W = cda_pkg::AMOUNT_W + 1;
	localparam int unsigned Q12_W = 9;
	localparam int unsigned P12_W = T_W + 12;

	logic [cda_pkg::OPCODE_W-1:0] op_q;
	logic [cda_pkg::AMOUNT_W-1:0] n_q;
	logic [REM_W-1:0]             rem_q;
	logic [cda_pkg::DAY_W-1:0]    d_q;
	logic [cda_pkg::MONTH_W-1:0]  m_q;
	logic [cda_pkg::YEAR_W-1:0]   y_q;
	logic                         ovf_q;
	logic                         bad_q;
	logic [YSUM_W-1:0]            ysum_q;
	logic [Q12_W-1:0]             q12_q;

	logic [Q100_W-1:0] q100_s1;
	logic              leap_s2;

	logic                         out_valid_q;
	logic [cda_pkg::DAY_W-1:0]    end_day_q;
	logic [cda_pkg::MONTH_W-1:0]  end_month_q;
	logic [cda_pkg::YEAR_W-1:0]   end_year_q;
	logic                         ovf_out_q;
	logic                         bad_out_q;

	logic [cda_pkg::AMOUNT_W-1:0] n_sat;
	logic [cda_pkg::DAY_W-1:0]    mlen;
	logic [cda_pkg::DAY_W-1:0]    left;
	logic                         fits;
	logic [T_W-1:0]               t;
	logic [P100_W-1:0]            p100;
	logic [P12_W-1:0]             p12;
	logic [T_W-1:0]               mrem;

	assign n_sat = (32'(amount) > AMOUNT_MAX) ? cda_pkg::AMOUNT_W'(AMOUNT_MAX) : amount;
	assign mlen  = cda_pkg::month_len(m_q, leap_s2);
	assign left  = mlen - d_q;
	assign fits  = CMP_W'(rem_q) <= CMP_W'(left);
	assign t     = T_W'(m_q) - T_W'(cda_pkg::MONTH_JAN) + T_W'(n_q);
	assign p100  = P100_W'(y_q) * P100_W'(cda_pkg::DIV100_MUL);
	assign p12   = P12_W'(t) * P12_W'(cda_pkg::DIV12_MUL);
	assign mrem  = t - T_W'(q12_q) * T_W'(cda_pkg::MONTHS_PER_YEAR);

	assign stat.date_ok   = (d_q != '0) && (d_q <= mlen);
	assign stat.opcode    = op_q;
	assign stat.walk_fits = fits;
	assign stat.month_dec = (m_q == cda_pkg::MONTH_DEC);
	assign stat.year_max  = (y_q >= cda_pkg::YEAR_MAX);
	assign stat.out_free  = !out_valid_q || out_ready;

	// Leap flag follows y_q through the registers q100_s1 and leap_s2; the controller waits after each year change.
	always_ff @(posedge clk) begin
		q100_s1 <= p100[cda_pkg::DIV100_SH +: Q100_W];
		leap_s2 <= (y_q[1:0] == 2'b00) &&
			((CMP_W'(q100_s1) * CMP_W'(100) != CMP_W'(y_q)) || (q100_s1[1:0] == 2'b00));
	end

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			cda_pkg::CMD_LOAD: begin
				op_q  <= opcode;
				n_q   <= n_sat;
				rem_q <= (opcode == cda_pkg::OP_WEEKS) ?
					REM_W'(cda_pkg::YEAR_W'(n_sat) * cda_pkg::YEAR_W'(cda_pkg::DAYS_PER_WEEK)) :
					REM_W'(n_sat);
				d_q   <= start_day;
				m_q   <= start_month;
				y_q   <= start_year;
				ovf_q <= 1'b0;
				bad_q <= 1'b0;
			end
			cda_pkg::CMD_BAD: bad_q <= 1'b1;
			cda_pkg::CMD_WALK: begin
				if (fits) begin
					d_q   <= cda_pkg::DAY_W'(CMP_W'(d_q) + CMP_W'(rem_q));
					rem_q <= '0;
				end else begin
					rem_q <= REM_W'(CMP_W'(rem_q) - CMP_W'(left) - CMP_W'(1));
					d_q   <= cda_pkg::DAY_FIRST;
					if (m_q == cda_pkg::MONTH_DEC) begin
						if (y_q >= cda_pkg::YEAR_MAX) begin
							d_q   <= cda_pkg::DAY_DEC_LAST;
							y_q   <= cda_pkg::YEAR_MAX;
							ovf_q <= 1'b1;
						end else begin
							m_q <= cda_pkg::MONTH_JAN;
							y_q <= y_q + 1'b1;
						end
					end else begin
						m_q <= m_q + 1'b1;
					end
				end
			end
			cda_pkg::CMD_MDIV: q12_q <= p12[cda_pkg::DIV12_SH +: Q12_W];
			cda_pkg::CMD_MAPPLY: begin
				m_q    <= cda_pkg::MONTH_W'(mrem) + cda_pkg::MONTH_JAN;
				ysum_q <= YSUM_W'(y_q) + YSUM_W'(q12_q);
			end
			cda_pkg::CMD_YADD: begin
				if (op_q == cda_pkg::OP_YEARS) begin
					ysum_q <= YSUM_W'(y_q) + YSUM_W'(n_q);
				end else begin
					ysum_q <= YSUM_W'(y_q) +
						YSUM_W'(n_q) * YSUM_W'(cda_pkg::YEARS_PER_DECADE);
				end
			end
			cda_pkg::CMD_YSAT: begin
				if (ysum_q > YSUM_W'(cda_pkg::YEAR_MAX)) begin
					y_q   <= cda_pkg::YEAR_MAX;
					ovf_q <= 1'b1;
				end else begin
					y_q <= cda_pkg::YEAR_W'(ysum_q);
				end
			end
			cda_pkg::CMD_CLAMP: begin
				if (d_q > mlen) begin
					d_q <= mlen;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.cmd == cda_pkg::CMD_EMIT) begin
			end_day_q   <= d_q;
			end_month_q <= m_q;
			end_year_q  <= y_q;
			ovf_out_q   <= ovf_q;
			bad_out_q   <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.cmd == cda_pkg::CMD_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign end_day       = end_day_q;
	assign end_month     = end_month_q;
	assign end_year      = end_year_q;
	assign year_overflow = ovf_out_q;
	assign bad_date      = bad_out_q;

endmodule

>>> src/cda_checker.sv
// Port-level checks for the calendar date adder, attached by bind.
// Depends on cda_pkg and on the ports of calendar_date_adder_unit.
module cda_port_checks (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [cda_pkg::DAY_W-1:0]    end_day,
	input logic [cda_pkg::MONTH_W-1:0]  end_month,
	input logic [cda_pkg::YEAR_W-1:0]   end_year,
	input logic                         year_overflow,
	input logic                         bad_date
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(end_day) && $stable(end_month) &&
		$stable(end_year) && $stable(year_overflow) && $stable(bad_date))
		else $error("Stalled response changed.");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Request taken while a request is in work.");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bad_date |-> !year_overflow)
		else $error("Overflow flagged on an invalid date.");

	a_overflow_year: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && year_overflow |-> end_year == cda_pkg::YEAR_MAX)
		else $error("Overflow flagged below the maximum year.");

	a_result_date: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !bad_date |-> end_day != '0 && end_month >= cda_pkg::MONTH_JAN &&
		end_month <= cda_pkg::MONTH_DEC)
		else $error("Result date outside the calendar.");

endmodule

bind calendar_date_adder_unit cda_port_checks u_cda_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.end_day       (rsp.end_day),
	.end_month     (rsp.end_month),
	.end_year      (rsp.end_year),
	.year_overflow (rsp.year_overflow),
	.bad_date      (rsp.bad_date)
);

>>> tb/cda_checker.sv
// Checker for the calendar date adder: watches the request and response channels,
// predicts each result from the accepted request and compares it field by field.
// Depends on cda_pkg, cda_req_if and cda_rsp_if.
module cda_checker #(
	parameter int unsigned AMOUNT_LIMIT = cda_pkg::AMOUNT_MAX_DEF
) (
	input  logic clk,
	input  logic arst_n,
	cda_req_if   req,
	cda_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import cda_pkg::*;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic               year_overflow;
		logic               bad_date;
	} date_result_t;

	date_result_t expected_dates[$];
	int           error_count   = 0;
	int           pending_count = 0;

	assign mismatches  = error_count;
	assign outstanding = pending_count;

	function automatic bit is_leap(input int unsigned year);
		return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
	endfunction

	function automatic int unsigned days_in(input int unsigned month, input int unsigned year);
		int unsigned days;
		case (month)
			MONTH_FEB:       days = is_leap(year) ? 29 : 28;
			4, 6, 9, 11:     days = 30;
			default:         days = 31;
		endcase
		return days;
	endfunction

	function automatic date_result_t advance_date(input logic [OPCODE_W-1:0] op,
		input logic [AMOUNT_W-1:0] amount, input logic [DAY_W-1:0] day,
		input logic [MONTH_W-1:0] month, input logic [YEAR_W-1:0] year);
		date_result_t res;
		int unsigned  n;
		int unsigned  d;
		int unsigned  m;
		int unsigned  y;
		int unsigned  rem;
		int unsigned  room;
		int unsigned  span;
		bit           ovf;
		bit           bad;
		n   = amount;
		d   = day;
		m   = month;
		y   = year;
		ovf = 1'b0;
		bad = 1'b0;
		if (n > AMOUNT_LIMIT) begin
			n = AMOUNT_LIMIT;
		end
		if (m < MONTH_JAN || m > MONTH_DEC || d < 1 || d > days_in(m, y)) begin
			bad = 1'b1;
		end else begin
			case (op)
				OP_DAYS, OP_WEEKS: begin
					rem = (op == OP_WEEKS) ? n * DAYS_PER_WEEK : n;
					while (rem > 0 && !ovf) begin
						room = days_in(m, y) - d;
						if (rem <= room) begin
							d   = d + rem;
							rem = 0;
						end else begin
							rem = rem - room - 1;
							d   = 1;
							if (m == MONTH_DEC) begin
								if (y >= YEAR_MAX) begin
									d   = DAY_DEC_LAST;
									y   = YEAR_MAX;
									ovf = 1'b1;
								end else begin
									m = MONTH_JAN;
									y = y + 1;
								end
							end else begin
								m = m + 1;
							end
						end
					end
				end
				OP_MONTHS, OP_YEARS, OP_DECADES: begin
					if (op == OP_MONTHS) begin
						span = m - 1 + n;
						y    = y + span / MONTHS_PER_YEAR;
						m    = span % MONTHS_PER_YEAR + 1;
					end else if (op == OP_YEARS) begin
						y = y + n;
					end else begin
						y = y + n * YEARS_PER_DECADE;
					end
					if (y > YEAR_MAX) begin
						y   = YEAR_MAX;
						ovf = 1'b1;
					end
					if (d > days_in(m, y)) begin
						d = days_in(m, y);
					end
				end
				default: begin
				end
			endcase
		end
		res.day           = DAY_W'(d);
		res.month         = MONTH_W'(m);
		res.year          = YEAR_W'(y);
		res.year_overflow = ovf;
		res.bad_date      = bad;
		return res;
	endfunction

	function automatic int field_differs(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
		return (want != got) ? 1 : 0;
	endfunction

	always @(posedge clk) begin : watch
		date_result_t want;
		int           wrong;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_dates.size() == 0) begin
					$display("%0t: result %0d/%0d/%0d ovf %0b bad %0b with no request pending",
						$time, rsp.end_day, rsp.end_month, rsp.end_year,
						rsp.year_overflow, rsp.bad_date);
					error_count++;
				end else begin
					want  = expected_dates.pop_front();
					wrong = 0;
					wrong += field_differs("end_day", want.day, rsp.end_day);
					wrong += field_differs("end_month", want.month, rsp.end_month);
					wrong += field_differs("end_year", want.year, rsp.end_year);
					wrong += field_differs("year_overflow", want.year_overflow,
						rsp.year_overflow);
					wrong += field_differs("bad_date", want.bad_date, rsp.bad_date);
					if (wrong != 0) begin
						error_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				expected_dates.push_back(advance_date(req.opcode, req.amount, req.start_day,
					req.start_month, req.start_year));
			end
			pending_count = expected_dates.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Top of the calendar date adder testbench: clock, reset, request stimulus and
// response stalls around the unit, with cda_checker judging every transfer.
// Depends on cda_pkg, cda_req_if, cda_rsp_if, calendar_date_adder_unit and cda_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cda_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 4_000_000;
	localparam int unsigned RANDOM_ITEMS = 600;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam logic [OPCODE_W-1:0] OP_RESERVED_FIRST = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_RESERVED_LAST  = 3'd7;
	localparam logic [AMOUNT_W-1:0] AMOUNT_TOP        = '1;

	logic        clk;
	logic        arst_n;
	int unsigned cycle_count = 0;
	bit          source_calm = 1'b0;
	int          mismatches;
	int          outstanding;

	cda_req_if req ();
	cda_rsp_if rsp ();

	calendar_date_adder_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	cda_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int unsigned idle_cycles();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			return 0;
		end else if (pick < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Response stalls, with calm stretches where the sink takes every transfer once a running stall ends.
	initial begin : sink
		int unsigned stall_left;
		stall_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (((cycle_count / 1500) % 4) != 0 && $urandom_range(0, 3) == 0) begin
				stall_left = idle_cycles();
				rsp.ready <= (stall_left == 0);
				if (stall_left > 0) begin
					stall_left--;
				end
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [AMOUNT_W-1:0] amount,
		input logic [DAY_W-1:0] day, input logic [MONTH_W-1:0] month,
		input logic [YEAR_W-1:0] year);
		int unsigned gap;
		gap = source_calm ? 0 : idle_cycles();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.opcode      <= op;
		req.amount      <= amount;
		req.start_day   <= day;
		req.start_month <= month;
		req.start_year  <= year;
		req.valid       <= 1'b1;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic random_request();
		logic [OPCODE_W-1:0] op;
		logic [AMOUNT_W-1:0] amount;
		logic [DAY_W-1:0]    day;
		logic [MONTH_W-1:0]  month;
		logic [YEAR_W-1:0]   year;
		int unsigned         pick;
		int unsigned         size_pick;
		int unsigned         year_pick;
		pick      = $urandom_range(0, 99);
		size_pick = $urandom_range(0, 99);
		year_pick = $urandom_range(0, 99);
		if (pick < 5) begin
			op = OPCODE_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
		end else begin
			op = OPCODE_W'($urandom_range(OP_DAYS, OP_DECADES));
		end
		if (size_pick < 60) begin
			amount = AMOUNT_W'($urandom_range(0, 63));
		end else if (size_pick < 85) begin
			amount = AMOUNT_W'($urandom_range(0, 511));
		end else begin
			amount = AMOUNT_W'($urandom_range(0, AMOUNT_FIELD_MAX));
		end
		if (year_pick < 10) begin
			year = YEAR_W'($urandom_range(YEAR_MAX - 50, YEAR_MAX));
		end else if (year_pick < 20) begin
			year = YEAR_W'($urandom_range(0, 50));
		end else if (year_pick < 40) begin
			year = YEAR_W'(100 * $urandom_range(0, 327));
		end else begin
			year = YEAR_W'($urandom_range(0, YEAR_MAX));
		end
		if (pick >= 5 && pick < 15) begin
			day   = DAY_W'($urandom_range(0, 31));
			month = MONTH_W'($urandom_range(0, 15));
		end else begin
			month = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
			day   = DAY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(28, 31) :
				$urandom_range(1, 27));
		end
		send_request(op, amount, day, month, year);
	endtask

	initial begin
		arst_n          <= 1'b0;
		req.valid       <= 1'b0;
		req.opcode      <= OP_DAYS;
		req.amount      <= '0;
		req.start_day   <= DAY_FIRST;
		req.start_month <= MONTH_JAN;
		req.start_year  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_DAYS, 0, 15, 6, 2024);
		send_request(OP_DAYS, 1, 28, MONTH_FEB, 1900);
		send_request(OP_DAYS, 1, 28, MONTH_FEB, 2000);
		send_request(OP_DAYS, 1, DAYS_FEB_LEAP, MONTH_FEB, 0);
		send_request(OP_DAYS, AMOUNT_TOP, DAY_FIRST, MONTH_JAN, 0);
		send_request(OP_DAYS, 1, DAY_DEC_LAST, MONTH_DEC, YEAR_MAX);
		send_request(OP_WEEKS, AMOUNT_TOP, DAY_DEC_LAST, MONTH_DEC, YEAR_MAX - 15'd70);
		send_request(OP_WEEKS, AMOUNT_TOP, DAY_FIRST, MONTH_JAN, 2000);
		send_request(OP_MONTHS, 1, 31, MONTH_JAN, 2023);
		send_request(OP_MONTHS, AMOUNT_TOP, DAY_DEC_LAST, MONTH_DEC, YEAR_MAX);
		send_request(OP_MONTHS, 0, 31, 10, 1999);
		send_request(OP_YEARS, 1, DAYS_FEB_LEAP, MONTH_FEB, 2000);
		send_request(OP_YEARS, AMOUNT_TOP, DAY_FIRST, MONTH_JAN, 28672);
		send_request(OP_YEARS, 1, DAY_FIRST, MONTH_JAN, YEAR_MAX);
		send_request(OP_DECADES, AMOUNT_TOP, 30, 4, 0);
		send_request(OP_DECADES, 4, DAYS_FEB_LEAP, MONTH_FEB, 1960);
		send_request(OP_DAYS, 5, DAY_FIRST, 0, 2020);
		send_request(OP_DAYS, 5, DAY_FIRST, 13, 2020);
		send_request(OP_WEEKS, AMOUNT_TOP, 31, 15, YEAR_MAX);
		send_request(OP_MONTHS, 3, 0, 7, 2020);
		send_request(OP_YEARS, 2, 31, 4, 2020);
		send_request(OP_DAYS, 1, DAYS_FEB_LEAP, MONTH_FEB, 1900);
		send_request(OP_RESERVED_FIRST, 100, 10, 3, 1234);
		send_request(OP_RESERVED_FIRST + 3'd1, 100, 10, 3, 1234);
		send_request(OP_RESERVED_LAST, AMOUNT_TOP, 31, MONTH_DEC, YEAR_MAX);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			source_calm = ((i / 40) % 4) == 1;
			random_request();
		end
		req.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/cda_pkg.sv
src/cda_req_if.sv
src/cda_rsp_if.sv
src/cda_ctrl.sv
src/cda_dpath.sv
src/calendar_date_adder_unit.sv
src/cda_checker.sv
tb/cda_checker.sv
tb/testbench.sv
